/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* design/sols_pkg.sv */
// ----------------------------------------------------------------------------
// sols_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sols_pkg;

	localparam int DEFAULT_DEPTH = 16;

	localparam int VAL_W      = 32;
	localparam int SLOT_W     = 4;
	localparam int POS_W      = 4;
	localparam int POL_W      = 2;
	localparam int CNT_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 2'd1;

	localparam logic [POL_W-1:0] POL_PLAIN     = 2'd0;
	localparam logic [POL_W-1:0] POL_TRANSPOSE = 2'd1;
	localparam logic [POL_W-1:0] POL_HEAD      = 2'd2;
	// Spare code; it acts as a plain search.
	localparam logic [POL_W-1:0] POL_UNUSED    = 2'd3;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;    // capture a new item
		logic scan;      // run the table scan
		logic wr_entry;  // store the captured value at the captured slot
		logic wb_hit;    // write the partner value into the hit position
		logic wb_other;  // write the key into the partner position
		logic deliver;   // load the result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_search;   // incoming item is a search
		logic limit_zero;  // incoming search has nothing to scan
		logic hit;         // scan found its first match this cycle
		logic miss;        // scan ran off the end without a match
		logic do_swap;     // the current hit reorders the table
		logic out_free;    // output register can take a result
	} status_t;

endpackage

/* design/sols_ctrl.sv */
// ----------------------------------------------------------------------------
// sols_ctrl
// Sequencer for write, scan, swap write-back and result delivery.
// ----------------------------------------------------------------------------
module sols_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  sols_pkg::status_t st,
	output sols_pkg::cmd_t    cmd
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_WRITE    = 6'b000010,
		ST_SCAN     = 6'b000100,
		ST_WB_HIT   = 6'b001000,
		ST_WB_OTHER = 6'b010000,
		ST_DONE     = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (!st.is_search) begin
						state_d = ST_WRITE;
					end else if (st.limit_zero) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_WRITE: begin
				cmd.wr_entry = 1'b1;
				state_d      = ST_DONE;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (st.hit) begin
					state_d = st.do_swap ? ST_WB_HIT : ST_DONE;
				end else if (st.miss) begin
					state_d = ST_DONE;
				end
			end
			ST_WB_HIT: begin
				cmd.wb_hit = 1'b1;
				state_d    = ST_WB_OTHER;
			end
			ST_WB_OTHER: begin
				cmd.wb_other = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.deliver = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* design/sols_dp.sv */
// ----------------------------------------------------------------------------
// sols_dp
// Table memory, scan pipeline, swap registers, configuration and output.
// ----------------------------------------------------------------------------
module sols_dp #(
	parameter int TABLE_DEPTH = sols_pkg::DEFAULT_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               command,
	input  logic [sols_pkg::SLOT_W-1:0]        slot,
	input  logic signed [sols_pkg::VAL_W-1:0]  operand_value,
	input  logic                               cfg_valid,
	input  logic [sols_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sols_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  sols_pkg::cmd_t                     cmd,
	output sols_pkg::status_t                  st,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               out_found,
	output logic [sols_pkg::POS_W-1:0]         out_position
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = (CW > sols_pkg::CNT_W) ? CW : sols_pkg::CNT_W;

	logic [sols_pkg::VAL_W-1:0] mem [TABLE_DEPTH];

	logic [sols_pkg::POL_W-1:0] policy_q;
	logic [sols_pkg::CNT_W-1:0] entries_q;

	logic [sols_pkg::VAL_W-1:0] key_q;
	logic [AW-1:0]              slot_q;
	logic                       wr_ok_q;
	logic [CW-1:0]              limit_q;
	logic [CW-1:0]              idx_q;
	logic                       cmp_valid_q;
	logic [AW-1:0]              cmp_pos_q;
	logic [sols_pkg::VAL_W-1:0] rd_data_q;
	logic [sols_pkg::VAL_W-1:0] prev_q;
	logic [sols_pkg::VAL_W-1:0] head_q;
	logic [sols_pkg::VAL_W-1:0] swap_data_q;
	logic [AW-1:0]              swap_addr_q;
	logic                       found_q;
	logic [AW-1:0]              pos_q;
	logic                       out_valid_q;
	logic                       out_found_q;
	logic [sols_pkg::POS_W-1:0] out_pos_q;

	logic [LW-1:0]              entries_ext;
	logic [LW-1:0]              depth_l;
	logic [LW-1:0]              limit_l;
	logic [LW-1:0]              slot_ext;
	logic [LW-1:0]              pos_ext;
	logic                       eq;
	logic                       issue;
	logic                       hit;
	logic                       use_head;
	logic                       mem_we;
	logic [AW-1:0]              mem_wa;
	logic [sols_pkg::VAL_W-1:0] mem_wd;

	assign entries_ext = LW'(entries_q);
	assign depth_l     = LW'(TABLE_DEPTH);
	assign limit_l     = (entries_ext > depth_l) ? depth_l : entries_ext;
	assign slot_ext    = LW'(slot);
	assign pos_ext     = LW'(pos_q);

	assign eq       = (rd_data_q == key_q);
	assign issue    = cmd.scan && (idx_q != limit_q);
	assign hit      = cmd.scan && cmp_valid_q && eq;
	assign use_head = (policy_q == sols_pkg::POL_HEAD);

	assign st.is_search  = (command == sols_pkg::CMD_SEARCH);
	assign st.limit_zero = (limit_l == '0);
	assign st.hit        = hit;
	assign st.miss       = cmd.scan && cmp_valid_q && !eq && (idx_q == limit_q);
	assign st.do_swap    = ((policy_q == sols_pkg::POL_TRANSPOSE) || use_head)
	                       && (cmp_pos_q != '0);
	assign st.out_free   = !out_valid_q || out_ready;

	// One write port shared by entry writes and the two swap write-backs.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = slot_q;
		mem_wd = key_q;
		priority if (cmd.wr_entry) begin
			mem_we = wr_ok_q;
		end else if (cmd.wb_hit) begin
			mem_we = 1'b1;
			mem_wa = pos_q;
			mem_wd = swap_data_q;
		end else if (cmd.wb_other) begin
			mem_we = 1'b1;
			mem_wa = swap_addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (issue) begin
			rd_data_q <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= sols_pkg::POL_PLAIN;
			entries_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == sols_pkg::REG_POLICY) begin
				policy_q <= cfg_data[sols_pkg::POL_W-1:0];
			end else if (cfg_index == sols_pkg::REG_ENTRIES) begin
				entries_q <= cfg_data[sols_pkg::CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cmp_valid_q <= 1'b0;
		end else if (cmd.accept) begin
			idx_q       <= '0;
			cmp_valid_q <= 1'b0;
		end else if (cmd.scan) begin
			if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			cmp_valid_q <= issue && !hit;
		end else begin
			cmp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q   <= operand_value;
			slot_q  <= slot_ext[AW-1:0];
			wr_ok_q <= (slot_ext < depth_l);
			limit_q <= limit_l[CW-1:0];
			found_q <= 1'b0;
			pos_q   <= '0;
		end
		if (cmd.scan) begin
			cmp_pos_q <= idx_q[AW-1:0];
			if (cmp_valid_q) begin
				prev_q <= rd_data_q;
				if (cmp_pos_q == '0) begin
					head_q <= rd_data_q;
				end
			end
			if (hit) begin
				found_q     <= 1'b1;
				pos_q       <= cmp_pos_q;
				swap_addr_q <= use_head ? '0 : (cmp_pos_q - AW'(1));
				swap_data_q <= use_head ? head_q : prev_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.deliver) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deliver) begin
			out_found_q <= found_q;
			out_pos_q   <= pos_ext[sols_pkg::POS_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign out_found    = out_found_q;
	assign out_position = out_pos_q;

endmodule

/* design/self_organizing_linear_search_top.sv */
// ----------------------------------------------------------------------------
// self_organizing_linear_search_top
// Self-organizing search table with write, scan and move-on-hit policies.
// ----------------------------------------------------------------------------
// Usage: items enter on the s_ stream. s_tuser is the command (0 writes
// operand_value into the table at slot, 1 searches for operand_value as a
// key). Every item gives exactly one result item on the m_ stream: found in
// m_tuser and the hit position in m_tdata, both zero for writes and misses.
// The cfg channel writes register 0 (policy) and register 1 (entries_in_use);
// it is always ready and must only be used while the block is idle.
// Timing: one item at a time; s_tready is high only while the sequencer idles.
// A write passes through the write and done states to the output register. A
// search reads one entry per cycle through the table's single read port and
// stops at its first match; when the policy moves the hit entry, the two
// swapped values are stored one after the other. The next item can be taken
// once the result is loaded into the output register.
// Stalls: a result waits in the output register while the next item is taken;
// that item's result is held until the register frees. Reset clears the state,
// the configuration registers and output valid; table contents are undefined
// until entries are written.
module self_organizing_linear_search_top #(
	parameter int TABLE_DEPTH = sols_pkg::DEFAULT_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input items.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [39:0]                         s_tdata,  // slot[3:0], operand_value[35:4], zeros
	input  logic                                s_tuser,  // command
	// Result items.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,  // position[3:0], zeros
	output logic                                m_tuser,  // found
	// Configuration writes.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sols_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sols_pkg::CFG_DATA_W-1:0]     cfg_data
);

	`include "assert_macros.svh"

	sols_pkg::cmd_t             cmd;
	sols_pkg::status_t          st;
	logic [sols_pkg::POS_W-1:0] position;

	// Registers are plain flip-flops, so a write is taken in any cycle.
	assign cfg_ready = 1'b1;

	sols_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	sols_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.command       (s_tuser),
		.slot          (s_tdata[3:0]),
		.operand_value (s_tdata[35:4]),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.st            (st),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_found     (m_tuser),
		.out_position  (position)
	);

	assign m_tdata = {4'b0000, position};

	// Once an item is taken the sequencer is not ready in the following cycle.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// The scan stops on the cycle after its first match.
	`ASSERT_NEXT(a_scan_stops_on_hit, clk, arst_n, cmd.scan && st.hit, !cmd.scan)
	// The two swap write-backs always come as a pair.
	`ASSERT_NEXT(a_swap_pair, clk, arst_n, cmd.wb_hit, cmd.wb_other)
	// Writes and misses report position zero.
	`ASSERT_SAME(a_miss_pos_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == 8'd0)

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the self-organizing search table: a short table of
// directed items, then random write and search traffic under every policy and
// several scan lengths, checked result by result against a local predictor.
// ----------------------------------------------------------------------------
module tb;

	localparam int DEPTH        = sols_pkg::DEFAULT_DEPTH;
	localparam int PHASES       = 9;
	localparam int PHASE_ITEMS  = 50;
	localparam int SETTLE       = 4;
	localparam int TAIL_CYCLES  = 25;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 3000;

	typedef logic [sols_pkg::SLOT_W-1:0]     slot_t;
	typedef logic [sols_pkg::CFG_DATA_W-1:0] cfg_word_t;

	// One expected result item: found travels in m_tuser, position in m_tdata.
	typedef struct packed {
		logic                       found;
		logic [sols_pkg::POS_W-1:0] position;
	} lookup_result_t;

	// One row of the directed plan: either a register write or an input item,
	// with an optional typed-in expectation.
	typedef struct {
		bit                              is_cfg;
		logic [sols_pkg::CFG_IDX_W-1:0]  cfg_idx;
		logic [sols_pkg::CFG_DATA_W-1:0] cfg_val;
		logic                            cmd;
		logic [sols_pkg::SLOT_W-1:0]     slot;
		logic [sols_pkg::VAL_W-1:0]      value;
		bit                              typed;
		lookup_result_t                  answer;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [39:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;
	logic m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [sols_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sols_pkg::CFG_DATA_W-1:0] cfg_data;

	// Shadow copy of the block's table and registers, kept by the predictor.
	logic [sols_pkg::VAL_W-1:0] shadow_table [DEPTH];
	logic [sols_pkg::POL_W-1:0] shadow_policy;
	logic [sols_pkg::CNT_W-1:0] shadow_scan_len;

	lookup_result_t pending_results[$];
	plan_row_t plan[$];

	int send_idle_pct;
	int recv_idle_pct;
	bit hold_request;
	int fail_count;
	int items_sent;
	int searches_sent;
	int hits_predicted;
	int results_checked;
	int cfg_writes;

	self_organizing_linear_search_top #(
		.TABLE_DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Predicts the result of one accepted item and applies the same table
	// update the block makes: a write stores the value, a search hit may move
	// the entry toward the head depending on the policy.
	function automatic lookup_result_t lookup_and_reorder(input logic cmd,
			input logic [sols_pkg::SLOT_W-1:0] slot,
			input logic [sols_pkg::VAL_W-1:0] value);
		lookup_result_t res;
		int scan_len;
		int hit_pos;
		logic [sols_pkg::VAL_W-1:0] held;
		res = '0;
		hit_pos = -1;
		if (cmd == sols_pkg::CMD_WRITE) begin
			shadow_table[slot] = value;
		end else begin
			// Scan lengths above the table depth saturate at the depth.
			scan_len = (shadow_scan_len > DEPTH) ? DEPTH : int'(shadow_scan_len);
			for (int i = 0; i < scan_len; i++) begin
				if (hit_pos < 0 && shadow_table[i] == value)
					hit_pos = i;
			end
			if (hit_pos >= 0) begin
				res.found = 1'b1;
				res.position = hit_pos[sols_pkg::POS_W-1:0];
				// A hit already at the head never moves; the spare policy
				// code acts as a plain search.
				if (shadow_policy == sols_pkg::POL_TRANSPOSE && hit_pos > 0) begin
					held = shadow_table[hit_pos - 1];
					shadow_table[hit_pos - 1] = shadow_table[hit_pos];
					shadow_table[hit_pos] = held;
				end else if (shadow_policy == sols_pkg::POL_HEAD && hit_pos > 0) begin
					held = shadow_table[0];
					shadow_table[0] = shadow_table[hit_pos];
					shadow_table[hit_pos] = held;
				end
			end
		end
		return res;
	endfunction

	function automatic plan_row_t item_row(input logic cmd,
			input logic [sols_pkg::SLOT_W-1:0] slot,
			input logic [sols_pkg::VAL_W-1:0] value, input bit typed, input logic found,
			input logic [sols_pkg::POS_W-1:0] position);
		plan_row_t row;
		row = '{default: '0};
		row.cmd = cmd;
		row.slot = slot;
		row.value = value;
		row.typed = typed;
		row.answer.found = found;
		row.answer.position = position;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(input logic [sols_pkg::CFG_IDX_W-1:0] idx,
			input logic [sols_pkg::CFG_DATA_W-1:0] val);
		plan_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.cfg_idx = idx;
		row.cfg_val = val;
		return row;
	endfunction

	// Offers one input item. Entered and left at a falling edge. The valid
	// stays high on return so that back-to-back items need no second
	// assignment in the same step; idling or the drain task lowers it.
	task automatic offer_item(input logic cmd, input logic [sols_pkg::SLOT_W-1:0] slot,
			input logic [sols_pkg::VAL_W-1:0] value, input bit typed,
			input lookup_result_t answer);
		lookup_result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0000, value, slot};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// The predictor always runs so the shadow table tracks the block,
		// even where the expectation was typed into the plan.
		predicted = lookup_and_reorder(cmd, slot, value);
		pending_results.push_back(typed ? answer : predicted);
		items_sent++;
		if (cmd == sols_pkg::CMD_SEARCH) begin
			searches_sent++;
			if (predicted.found)
				hits_predicted++;
		end
		@(negedge clk);
	endtask

	// Stops offering and waits until every expected result has come back,
	// so that the block is idle. Left at a falling edge.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	// One register write; the block must be idle. Entered and left at a
	// falling edge at which nothing has been assigned yet.
	task automatic write_register(input logic [sols_pkg::CFG_IDX_W-1:0] idx,
			input logic [sols_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == sols_pkg::REG_POLICY)
			shadow_policy = val[sols_pkg::POL_W-1:0];
		else if (idx == sols_pkg::REG_ENTRIES)
			shadow_scan_len = val[sols_pkg::CNT_W-1:0];
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Result side: m_tready changes at the falling edge, results are taken
	// at the rising edge. A hold request from the stimulus makes this process
	// refuse results for a long stretch that it counts itself, while the
	// sender keeps offering items and the block backs up.
	initial begin
		int stall_left;
		lookup_result_t want;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				results_checked++;
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result item: found=%0b tdata=%h",
							m_tuser, m_tdata);
				end else begin
					want = pending_results.pop_front();
					if (m_tuser !== want.found || m_tdata !==
							{{(8 - sols_pkg::POS_W){1'b0}}, want.position}) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"result %0d mismatch: expected found=%0b pos=%0d,",
								" got found=%0b tdata=%h"}, results_checked,
								want.found, want.position, m_tuser, m_tdata);
					end
				end
			end
		end
	end

	// Watchdog: ends the run when no item moves on any channel for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
					|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
		$display("self_organizing_linear_search_top regression: fail");
		$finish;
	end

	initial begin
		logic [sols_pkg::VAL_W-1:0] seed_vals [8];
		logic [sols_pkg::VAL_W-1:0] value;
		logic [sols_pkg::SLOT_W-1:0] slot;
		logic cmd;
		int scan_lens [PHASES];
		int roll;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 1'b0;
		fail_count = 0;
		items_sent = 0;
		searches_sent = 0;
		hits_predicted = 0;
		results_checked = 0;
		cfg_writes = 0;
		shadow_policy = sols_pkg::POL_PLAIN;
		shadow_scan_len = '0;
		foreach (shadow_table[i])
			shadow_table[i] = '0;

		// Directed plan. Right after reset nothing is scanned, so a search
		// misses without touching the (still unwritten) table. The table is
		// then filled completely, so no later search reads a stale entry.
		seed_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE};
		plan.push_back(item_row(sols_pkg::CMD_SEARCH, 4'd0, 32'h0000_0000, 1'b1, 1'b0, 4'd0));
		for (int s = 0; s < DEPTH; s++) begin
			value = (s < 8) ? seed_vals[s] : {28'h1357_000, s[3:0]};
			plan.push_back(item_row(sols_pkg::CMD_WRITE, s[sols_pkg::SLOT_W-1:0], value,
				1'b1, 1'b0, 4'd0));
		end
		plan.push_back(cfg_row(sols_pkg::REG_ENTRIES, 5'd16));
		plan.push_back(item_row(sols_pkg::CMD_SEARCH, 4'd0, 32'h8000_0000, 1'b1, 1'b1, 4'd0));
		plan.push_back(item_row(sols_pkg::CMD_SEARCH, 4'd0, 32'h7FFF_FFFF, 1'b1, 1'b1, 4'd1));
		plan.push_back(item_row(sols_pkg::CMD_SEARCH, 4'd0, 32'h1357_000F, 1'b1, 1'b1, 4'd15));
		// A key that is nowhere in the table scans all sixteen entries.
		plan.push_back(item_row(sols_pkg::CMD_SEARCH, 4'd0, 32'hDEAD_BEEF, 1'b1, 1'b0, 4'd0));
		plan.push_back(cfg_row(sols_pkg::REG_POLICY, {3'b000, sols_pkg::POL_TRANSPOSE}));
		// Transposition of a hit at the head does nothing.
		plan.push_back(item_row(sols_pkg::CMD_SEARCH, 4'd0, 32'h8000_0000, 1'b1, 1'b1, 4'd0));
		plan.push_back(item_row(sols_pkg::CMD_SEARCH, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 4'd0));
		plan.push_back(cfg_row(sols_pkg::REG_POLICY, {3'b000, sols_pkg::POL_HEAD}));
		plan.push_back(item_row(sols_pkg::CMD_SEARCH, 4'd0, 32'h1357_0009, 1'b0, 1'b0, 4'd0));
		// Unused policy code and a scan length beyond the table depth.
		plan.push_back(cfg_row(sols_pkg::REG_POLICY, {3'b000, sols_pkg::POL_UNUSED}));
		plan.push_back(cfg_row(sols_pkg::REG_ENTRIES, 5'd31));
		plan.push_back(item_row(sols_pkg::CMD_SEARCH, 4'd0, 32'h1357_000C, 1'b0, 1'b0, 4'd0));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain_results();
				write_register(plan[i].cfg_idx, plan[i].cfg_val);
			end else begin
				offer_item(plan[i].cmd, plan[i].slot, plan[i].value,
					plan[i].typed, plan[i].answer);
			end
		end

		// Random phases: each one reprograms both registers, then sends a
		// mix of writes and searches. Most search keys are taken from the
		// current table so that hits, reordering and repeated hits dominate;
		// small write values make duplicate entries and first-match cases.
		scan_lens = '{16, 1, 31, 0, 8, 16, 17, 5, 16};
		scan_lens[7] = $urandom_range(0, 31);
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			unique case (phase / 3)
				0: begin
					send_idle_pct = 33;
					recv_idle_pct = 87;
				end
				1: begin
					send_idle_pct = 87;
					recv_idle_pct = 33;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_register(sols_pkg::REG_POLICY, cfg_word_t'(phase % 4));
			write_register(sols_pkg::REG_ENTRIES, cfg_word_t'(scan_lens[phase]));
			if (phase == 6)
				hold_request = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				slot = slot_t'($urandom_range(0, DEPTH - 1));
				if (roll < 30) begin
					cmd = sols_pkg::CMD_WRITE;
					value = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 7);
				end else begin
					cmd = sols_pkg::CMD_SEARCH;
					if (roll < 80)
						value = shadow_table[slot_t'($urandom_range(0, DEPTH - 1))];
					else if (roll < 90)
						value = $urandom_range(0, 7);
					else
						value = $urandom;
				end
				offer_item(cmd, slot, value, 1'b0, '0);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d items (%0d searches, %0d predicted hits), %0d register writes,",
			items_sent, searches_sent, hits_predicted, cfg_writes);
		$display("all four policy codes, scan lengths 0 to 31, and a long result stall");
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("self_organizing_linear_search_top regression: pass");
		end else begin
			$display("%0d failures, %0d results still expected", fail_count,
				pending_results.size());
			$display("self_organizing_linear_search_top regression: fail");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/sols_pkg.sv
design/sols_ctrl.sv
design/sols_dp.sv
design/self_organizing_linear_search_top.sv
bench/tb.sv
